@@ hdl/kdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the keypad debounce and long-press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

	// Key codes and field widths.
	localparam int unsigned CODE_W      = 5;
	localparam int unsigned MATRIX_W    = 16;
	localparam int unsigned THRESH_W    = 8;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CODE_W-1:0] NO_KEY = CODE_W'(10);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_KEY  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_CODE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_THRESHOLD  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CODE_W-1:0]   RST_LONG_PRESS_KEY  = CODE_W'(8);
	localparam logic [CODE_W-1:0]   RST_LONG_PRESS_CODE = CODE_W'(17);
	localparam logic [THRESH_W-1:0] RST_HOLD_THRESHOLD  = THRESH_W'(100);

	// Code for each matrix position; positions without a code are flagged.
	typedef struct packed {
		logic              mapped;
		logic [CODE_W-1:0] code;
	} kdlp_key_entry_t;

	localparam kdlp_key_entry_t KEY_MAP [MATRIX_W] = '{
		'{1'b1, 5'd0},  '{1'b1, 5'd1},  '{1'b1, 5'd2},  '{1'b1, 5'd3},
		'{1'b1, 5'd4},  '{1'b1, 5'd5},  '{1'b1, 5'd6},  '{1'b1, 5'd7},
		'{1'b1, 5'd8},  '{1'b1, 5'd9},  '{1'b0, 5'd0},  '{1'b0, 5'd0},
		'{1'b0, 5'd0},  '{1'b1, 5'd11}, '{1'b1, 5'd12}, '{1'b1, 5'd16}
	};

	// Debounce state machine.
	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_CONFIRM   = 3'd1,
		ST_WAIT_REL  = 3'd2,
		ST_HOLD      = 3'd3,
		ST_WAIT_LONG = 3'd4
	} kdlp_state_t;

	// Configuration seen by the state machine.
	typedef struct packed {
		logic [CODE_W-1:0]   long_press_key;
		logic [CODE_W-1:0]   long_press_code;
		logic [THRESH_W-1:0] hold_threshold;
	} kdlp_cfg_t;

	// Result of one scan tick.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              written;
	} kdlp_res_t;

endpackage

@@ hdl/kdlp_decode.sv @@
// ----------------------------------------------------------------------------
// kdlp_decode
// Turns the sensed key matrix into one key code; the last mapped pressed
// position in scan order wins.
// ----------------------------------------------------------------------------
module kdlp_decode import kdlp_pkg::*; (
	input  logic [MATRIX_W-1:0] matrix,
	output logic [CODE_W-1:0]   key
);

	// Scan all positions; a later pressed and mapped position overrides.
	always_comb begin
		key = NO_KEY;
		for (int i = 0; i < MATRIX_W; i++) begin
			if (matrix[i] && KEY_MAP[i].mapped) begin
				key = KEY_MAP[i].code;
			end
		end
	end

endmodule

@@ hdl/kdlp_fsm.sv @@
// ----------------------------------------------------------------------------
// kdlp_fsm
// Debounce and long-press state machine with the saved key, hold counter
// and code register.
// ----------------------------------------------------------------------------
module kdlp_fsm import kdlp_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [CODE_W-1:0] key,
	input  kdlp_cfg_t         cfg,
	output kdlp_res_t         res,
	output logic [CODE_W-1:0] code_now
);

	localparam int unsigned CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	kdlp_state_t            state_q, state_d;
	logic [CODE_W-1:0]      saved_key_q, saved_key_d;
	logic [COUNT_WIDTH-1:0] hold_count_q, hold_count_d;
	logic [CODE_W-1:0]      code_q, code_d;
	logic                   wrote;
	logic                   pressed;
	logic                   reached;

	assign pressed = (key != NO_KEY);

	// Saturating increment or clear of the hold counter, and threshold compare.
	always_comb begin
		hold_count_d = hold_count_q;
		if (state_q == ST_HOLD && pressed && hold_count_q != CNT_MAX) begin
			hold_count_d = hold_count_q + COUNT_WIDTH'(1);
		end
		if (state_q == ST_CONFIRM && pressed && key == cfg.long_press_key) begin
			hold_count_d = '0;
		end
		reached = (CMP_W'(hold_count_d) >= CMP_W'(cfg.hold_threshold));
	end

	// Next state and code register update.
	always_comb begin
		state_d     = state_q;
		saved_key_d = saved_key_q;
		code_d      = code_q;
		wrote       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (pressed) begin
					state_d = ST_CONFIRM;
				end
			end
			ST_CONFIRM: begin
				if (pressed) begin
					saved_key_d = key;
					if (key == cfg.long_press_key) begin
						state_d = ST_HOLD;
					end else begin
						code_d  = key;
						wrote   = 1'b1;
						state_d = ST_WAIT_REL;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WAIT_REL, ST_WAIT_LONG: begin
				if (!pressed) begin
					state_d = ST_IDLE;
				end
			end
			ST_HOLD: begin
				if (pressed) begin
					if (reached) begin
						code_d  = cfg.long_press_code;
						wrote   = 1'b1;
						state_d = ST_WAIT_LONG;
					end
				end else begin
					code_d  = saved_key_q;
					wrote   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers move only when an item passes to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			saved_key_q  <= '0;
			hold_count_q <= '0;
			code_q       <= NO_KEY;
		end else if (advance) begin
			state_q      <= state_d;
			saved_key_q  <= saved_key_d;
			hold_count_q <= hold_count_d;
			code_q       <= code_d;
		end
	end

	assign res.code    = code_d;
	assign res.written = wrote;
	assign code_now    = code_q;

endmodule

@@ hdl/keypad_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// keypad_debounce_long_press
// Scan-tick keypad decoder with two-tick debounce and long-press detection.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  key_matrix
//   out      output     out_valid/out_stall  latched_code, code_written
//   cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// Each item passes through the input register and then the result
// register; one item is taken every cycle while the output is not stalled.
// The rate is set by the state update between the two registers.
// Reset clears the handshake and the state machine and loads the configuration defaults.
// A stalled result holds the input register; in_stall rises only when the
// input register is full and cannot move on.
// ----------------------------------------------------------------------------
module keypad_debounce_long_press import kdlp_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [MATRIX_W-1:0]    key_matrix,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CODE_W-1:0]      latched_code,
	output logic                   code_written,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic                valid_s1;
	logic [MATRIX_W-1:0] matrix_s1;
	logic                valid_s2;
	logic [CODE_W-1:0]   code_s2;
	logic                written_s2;
	logic                advance;
	logic [CODE_W-1:0]   key;
	logic [CODE_W-1:0]   code_now;
	kdlp_cfg_t           cfg_q;
	kdlp_res_t           res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_key  <= RST_LONG_PRESS_KEY;
			cfg_q.long_press_code <= RST_LONG_PRESS_CODE;
			cfg_q.hold_threshold  <= RST_HOLD_THRESHOLD;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LONG_PRESS_KEY:  cfg_q.long_press_key  <= cfg_data[CODE_W-1:0];
				REG_LONG_PRESS_CODE: cfg_q.long_press_code <= cfg_data[CODE_W-1:0];
				REG_HOLD_THRESHOLD:  cfg_q.hold_threshold  <= cfg_data[THRESH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// An item moves on when the result register is empty or being taken.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			matrix_s1 <= key_matrix;
		end
	end

	kdlp_decode u_decode (
		.matrix (matrix_s1),
		.key    (key)
	);

	kdlp_fsm #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.key      (key),
		.cfg      (cfg_q),
		.res      (res),
		.code_now (code_now)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_s2    <= res.code;
			written_s2 <= res.written;
		end
	end

	assign out_valid    = valid_s2;
	assign latched_code = code_s2;
	assign code_written = written_s2;

	// The input side is held back only by a full, blocked input register.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked item");

	// A shown result always matches the code register it was taken from.
	a_result_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> latched_code == code_now)
		else $error("result code differs from code register");

	// The code register changes only when an item passes through.
	a_code_moves_with_item: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(code_now))
		else $error("code register changed without an item");

	// A write of the code is always carried into the result register.
	a_written_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.written |=> out_valid && code_written)
		else $error("code write lost on the way to the result register");

endmodule

@@ tb/keypad_debounce_long_press_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_debounce_long_press_tb
// Self-checking bench for the keypad debounce and long-press block. A short
// table of directed scan ticks and register writes is run first. Then come
// phases of fixed and random configuration, each driving press and release episodes
// with random matrix content. Every accepted scan tick goes through a local
// model of the state machine. Each result is compared with the oldest
// pending prediction. Both handshakes idle at random, and one long output
// stall backs the block up into its input.
// ----------------------------------------------------------------------------
module keypad_debounce_long_press_tb;
	import kdlp_pkg::*;

	localparam int HOLD_W         = 8;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASES         = 12;
	localparam int TICKS_PER_PHASE = 70;
	localparam logic [MATRIX_W-1:0] UNMAPPED_BITS = 16'h1C00;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	// One step of the directed table: a scan tick or a register write.
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_INDEX_W-1:0] idx;
		logic [MATRIX_W-1:0]    val;
		logic                   known;
		kdlp_res_t              res;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [MATRIX_W-1:0]    key_matrix;
	logic                   out_valid;
	logic                   out_stall;
	logic [CODE_W-1:0]      latched_code;
	logic                   code_written;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Local copy of the scanner state and its configuration.
	kdlp_state_t       scan_state;
	logic [CODE_W-1:0] held_key;
	logic [CODE_W-1:0] code_reg;
	logic [HOLD_W-1:0] hold_ticks;
	kdlp_cfg_t         cfg_copy;

	kdlp_res_t pending_codes [$];
	int        err_count = 0;
	int        results_seen = 0;
	int        idle_cycles = 0;
	bit        steady;

	keypad_debounce_long_press #(
		.COUNT_WIDTH(HOLD_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_matrix   (key_matrix),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.latched_code (latched_code),
		.code_written (code_written),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Code of one matrix position, or no key for the three unmapped positions.
	function automatic logic [CODE_W-1:0] bit_code(int b);
		if (b < 10)
			return CODE_W'(b);
		case (b)
			13: return CODE_W'(11);
			14: return CODE_W'(12);
			15: return CODE_W'(16);
			default: return NO_KEY;
		endcase
	endfunction

	// Matrix position of a key code; 16 when no position carries that code.
	function automatic int key_bit(logic [CODE_W-1:0] code);
		for (int b = 0; b < MATRIX_W; b++)
			if (bit_code(b) != NO_KEY && bit_code(b) == code)
				return b;
		return MATRIX_W;
	endfunction

	// The last pressed position in scan order that has a code wins.
	function automatic logic [CODE_W-1:0] decode_keys(logic [MATRIX_W-1:0] m);
		logic [CODE_W-1:0] code;
		code = NO_KEY;
		for (int b = 0; b < MATRIX_W; b++)
			if (m[b] && bit_code(b) != NO_KEY)
				code = bit_code(b);
		return code;
	endfunction

	// Advances the local scanner by one tick and returns the expected result.
	function automatic kdlp_res_t scan_tick(logic [MATRIX_W-1:0] m);
		logic [CODE_W-1:0] k;
		logic              wr;
		k  = decode_keys(m);
		wr = 1'b0;
		case (scan_state)
			ST_IDLE: begin
				if (k != NO_KEY)
					scan_state = ST_CONFIRM;
			end
			ST_CONFIRM: begin
				if (k != NO_KEY) begin
					held_key = k;
					if (k == cfg_copy.long_press_key) begin
						hold_ticks = '0;
						scan_state = ST_HOLD;
					end else begin
						code_reg   = k;
						wr         = 1'b1;
						scan_state = ST_WAIT_REL;
					end
				end else begin
					scan_state = ST_IDLE;
				end
			end
			ST_WAIT_REL, ST_WAIT_LONG: begin
				if (k == NO_KEY)
					scan_state = ST_IDLE;
			end
			ST_HOLD: begin
				if (k != NO_KEY) begin
					// The hold counter saturates instead of wrapping.
					if (hold_ticks != '1)
						hold_ticks = hold_ticks + 1'b1;
					if (hold_ticks >= cfg_copy.hold_threshold) begin
						code_reg   = cfg_copy.long_press_code;
						wr         = 1'b1;
						scan_state = ST_WAIT_LONG;
					end
				end else begin
					code_reg   = held_key;
					wr         = 1'b1;
					scan_state = ST_IDLE;
				end
			end
			default: scan_state = ST_IDLE;
		endcase
		return '{code: code_reg, written: wr};
	endfunction

	function automatic row_t tick_row(logic [MATRIX_W-1:0] m);
		row_t r;
		r      = '0;
		r.kind = ROW_TICK;
		r.val  = m;
		return r;
	endfunction

	function automatic row_t known_row(logic [MATRIX_W-1:0] m, logic [CODE_W-1:0] code,
			logic wr);
		row_t r;
		r       = tick_row(m);
		r.known = 1'b1;
		r.res   = '{code: code, written: wr};
		return r;
	endfunction

	function automatic row_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		row_t r;
		r      = '0;
		r.kind = ROW_REG;
		r.idx  = idx;
		r.val  = MATRIX_W'(d);
		return r;
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic int mapped_bit();
		int b;
		b = $urandom_range(0, 12);
		return (b < 10) ? b : b + 3;
	endfunction

	// Presses position b with random lower positions and unmapped positions,
	// so that b still decodes as the winning key.
	function automatic logic [MATRIX_W-1:0] press_matrix(int b);
		logic [31:0] lower;
		lower = (32'd1 << b) - 32'd1;
		return MATRIX_W'((32'd1 << b) | ($urandom & (lower | 32'(UNMAPPED_BITS))));
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("%0t ns %s: got %0d, want %0d", $time, what, got, want);
		err_count++;
	endtask

	// Offers one scan tick, waits for it to be taken and queues its prediction.
	task automatic send_item(logic [MATRIX_W-1:0] m);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		key_matrix <= m;
		do
			@(posedge clk);
		while (in_stall);
		pending_codes.push_back(scan_tick(m));
	endtask

	// Lets every pending result drain before the configuration is touched.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_LONG_PRESS_KEY:  cfg_copy.long_press_key  = d[CODE_W-1:0];
			REG_LONG_PRESS_CODE: cfg_copy.long_press_code = d[CODE_W-1:0];
			REG_HOLD_THRESHOLD:  cfg_copy.hold_threshold  = d[THRESH_W-1:0];
			default: ;
		endcase
	endtask

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		kdlp_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_codes.size() == 0) begin
				flag_mismatch("result with no item pending, code", int'(latched_code), 0);
			end else begin
				want = pending_codes.pop_front();
				if (latched_code !== want.code)
					flag_mismatch("latched_code", int'(latched_code), int'(want.code));
				if (code_written !== want.written)
					flag_mismatch("code_written", int'(code_written), int'(want.written));
			end
		end
	end

	// Ends the run when neither side has moved an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("keypad_debounce_long_press: mismatch");
				$finish;
			end
		end
	end

	// Output side: random stalls, long runs without any, and one long hold-off
	// that fills the block and pushes back on its input.
	initial begin
		bit pressed_back;
		int r;
		pressed_back = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (!pressed_back && results_seen >= 300) begin
				pressed_back = 1'b1;
				out_stall <= 1'b1;
				repeat (150) @(posedge clk);
			end else if (r < 45) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else if (r < 52) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(60, 120)) @(posedge clk);
			end else if (r < 92) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end
		end
	end

	// Stimulus: directed table, then phases of fixed and random configuration.
	initial begin
		row_t              directed_rows [25];
		logic [CODE_W-1:0] lp_key;
		logic [CODE_W-1:0] lp_code;
		logic [THRESH_W-1:0] lp_thr;
		int                sent;
		int                target;
		int                hold_len;
		int                r;
		bit                first_ep;
		bit                near;

		steady       = 1'b0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		key_matrix <= '0;
		cfg_wr_en  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		cfg_copy   = '{long_press_key: RST_LONG_PRESS_KEY, long_press_code: RST_LONG_PRESS_CODE,
			hold_threshold: RST_HOLD_THRESHOLD};
		scan_state = ST_IDLE;
		held_key   = '0;
		hold_ticks = '0;
		code_reg   = NO_KEY;

		// Reset configuration first: short presses, a full matrix, unmapped
		// positions, a release of the long-press key before the threshold
		// with another key held in between, then a threshold of one.
		directed_rows = '{
			known_row(16'h0000, NO_KEY, 1'b0),
			known_row(16'h0001, NO_KEY, 1'b0),
			known_row(16'h0001, 5'd0, 1'b1),
			known_row(16'h0000, 5'd0, 1'b0),
			known_row(16'hFFFF, 5'd0, 1'b0),
			known_row(16'hFFFF, 5'd16, 1'b1),
			known_row(16'h1C00, 5'd16, 1'b0),
			tick_row(16'h2000),
			known_row(16'h4000, 5'd12, 1'b1),
			tick_row(16'h0000),
			tick_row(16'h0100),
			tick_row(16'h0100),
			tick_row(16'h0002),
			known_row(16'h0000, 5'd8, 1'b1),
			tick_row(16'h0200),
			known_row(16'h0200, 5'd9, 1'b1),
			tick_row(16'h0000),
			reg_row(REG_LONG_PRESS_KEY, 8'd3),
			reg_row(REG_LONG_PRESS_CODE, 8'd31),
			reg_row(REG_HOLD_THRESHOLD, 8'd1),
			tick_row(16'h0008),
			tick_row(16'h0008),
			known_row(16'h0008, 5'd31, 1'b1),
			tick_row(16'h0008),
			tick_row(16'h0000)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[i].idx, CFG_DATA_W'(directed_rows[i].val));
			end else begin
				send_item(directed_rows[i].val);
				// Rows with a hand-written result replace the computed one.
				if (directed_rows[i].known)
					pending_codes[pending_codes.size() - 1] = directed_rows[i].res;
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			steady = (ph % 3 == 2);
			case (ph)
				0: begin
					lp_key  = CODE_W'(16);
					lp_code = CODE_W'(0);
					lp_thr  = THRESH_W'(255);
				end
				1: begin
					lp_key  = NO_KEY;
					lp_code = CODE_W'(31);
					lp_thr  = THRESH_W'(1);
				end
				2: begin
					lp_key  = CODE_W'(0);
					lp_code = CODE_W'(11);
					lp_thr  = THRESH_W'(2);
				end
				default: begin
					lp_key  = ($urandom_range(0, 4) != 0) ? bit_code(mapped_bit())
						: CODE_W'($urandom_range(0, 31));
					lp_code = CODE_W'($urandom_range(0, 31));
					r = $urandom_range(0, 99);
					if (r < 70)
						lp_thr = THRESH_W'($urandom_range(1, 10));
					else if (r < 90)
						lp_thr = THRESH_W'($urandom_range(11, 40));
					else
						lp_thr = THRESH_W'($urandom_range(200, 255));
				end
			endcase
			write_reg(REG_LONG_PRESS_KEY, CFG_DATA_W'(lp_key));
			write_reg(REG_LONG_PRESS_CODE, CFG_DATA_W'(lp_code));
			write_reg(REG_HOLD_THRESHOLD, CFG_DATA_W'(lp_thr));

			sent     = 0;
			first_ep = 1'b1;
			while (sent < TICKS_PER_PHASE) begin
				if (!first_ep && $urandom_range(0, 9) == 0) begin
					// Noise: raw matrix words.
					repeat ($urandom_range(1, 3)) begin
						send_item(MATRIX_W'($urandom));
						sent++;
					end
				end else begin
					// One press episode: hold a key, sometimes past the
					// threshold, with brief changes of key while held.
					target = key_bit(lp_key);
					if (target >= MATRIX_W || (!first_ep && $urandom_range(0, 1) == 0))
						target = mapped_bit();
					near = first_ep ||
						($urandom_range(0, 99) < ((lp_thr > 40) ? 2 : 25));
					hold_len = near ? int'(lp_thr) + $urandom_range(0, 4)
						: $urandom_range(1, 6);
					for (int t = 0; t < hold_len; t++) begin
						if (t > 0 && $urandom_range(0, 9) == 0)
							send_item(press_matrix(mapped_bit()));
						else
							send_item(press_matrix(target));
						sent++;
					end
					repeat ($urandom_range(1, 3)) begin
						if ($urandom_range(0, 3) == 0)
							send_item(MATRIX_W'($urandom) & UNMAPPED_BITS);
						else
							send_item('0);
						sent++;
					end
				end
				first_ep = 1'b0;
			end
		end

		settle();
		if (err_count == 0)
			$display("keypad_debounce_long_press: match");
		else
			$display("keypad_debounce_long_press: mismatch");
		$finish;
	end

endmodule
